/* hdl/bfa_pkg.sv */
package bfa_pkg;

	localparam int ROW_W  = 64;
	localparam int ROW_IW = 6;
	localparam int CNT_W  = 7;
	localparam int MAPB_W = 10;
	localparam int UNIT_W = 12;
	localparam int RUN_W  = 13;
	localparam int SROW_W = 8;
	localparam int IN_W   = 32;
	localparam int OUT_W  = 16;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_FIND  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_BIT_RD,
		ST_BIT_WB,
		ST_SCAN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic latch;
		logic clr_step;
		logic bit_rd;
		logic bit_wb;
		logic scan_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_end;
		logic out_free;
	} stat_t;

	// lowest set bit, ROW_W when none
	function automatic logic [CNT_W-1:0] first_one(input logic [ROW_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = CNT_W'(ROW_W);
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) r = CNT_W'(i);
		end
		return r;
	endfunction

	// highest set bit, ROW_W when none
	function automatic logic [CNT_W-1:0] last_one(input logic [ROW_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = CNT_W'(ROW_W);
		for (int i = 0; i < ROW_W; i++) begin
			if (v[i]) r = CNT_W'(i);
		end
		return r;
	endfunction

	function automatic logic [2:0] msb_pos(input logic [CNT_W-1:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 0; i < CNT_W; i++) begin
			if (v[i]) r = 3'(i);
		end
		return r;
	endfunction

endpackage

/* hdl/bfa_ram.sv */
module bfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/bfa_ctrl.sv */
module bfa_ctrl
	import bfa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  kind_t in_kind,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_kind)
						KIND_READ, KIND_WRITE: state_d = ST_BIT_RD;
						KIND_FIND:             state_d = ST_SCAN;
						default:               state_d = ST_CLEAR;
					endcase
				end
			end
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_RESULT;
			end
			ST_BIT_RD: state_d = ST_BIT_WB;
			ST_BIT_WB: state_d = ST_RESULT;
			ST_SCAN: begin
				if (stat.scan_end) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd           = '0;
		cmd.latch     = (state_q == ST_IDLE) && in_valid;
		cmd.clr_step  = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		cmd.bit_rd    = (state_q == ST_BIT_RD);
		cmd.bit_wb    = (state_q == ST_BIT_WB);
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.load_out  = (state_q == ST_RESULT) && stat.out_free;
	end

`ifndef SYNTH
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_INIT) |=> (state_q != ST_INIT))
		else $error("sweep after reset entered again");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> (state_q != ST_IDLE))
		else $error("accepted word left controller idle");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && !stat.out_free) |=> (state_q == ST_RESULT))
		else $error("result dropped while output busy");
`endif

endmodule

/* hdl/bfa_dp.sv */
module bfa_dp
	import bfa_pkg::*;
#(
	parameter int MAP_BYTES = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MAPB_W-1:0] cfg_wdata,
	input  kind_t             in_kind,
	input  logic [UNIT_W-1:0] in_unit_idx,
	input  logic              in_write_value,
	input  logic [RUN_W-1:0]  in_run_length,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  out_data
);

	localparam int ROWS      = (MAP_BYTES + 7) / 8;
	localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int UNITS_MAX = MAP_BYTES * 8;
	localparam int BYTES_CAP = (MAP_BYTES > 1023) ? 1023 : MAP_BYTES;

	logic [MAPB_W-1:0] map_bytes_q;
	kind_t             kind_q;
	logic [UNIT_W-1:0] idx_q;
	logic              wv_q;
	logic [RUN_W-1:0]  want_q;
	logic [2:0]        want_j_q;
	logic [ROW_IW-1:0] want_sh_q;
	logic              small_q;
	logic [ROW_AW-1:0] clr_row_q;
	logic [SROW_W-1:0] scan_row_q;
	logic              v_s1;
	logic [SROW_W-1:0] row_s1;
	logic [RUN_W-1:0]  carry_q;
	logic              bit_res_q;
	logic              found_q;
	logic [UNIT_W-1:0] start_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [MAPB_W-1:0] bytes_c;
	logic [SROW_W-1:0] rows_used_c;
	logic [RUN_W-1:0]  want_n;
	logic [2:0]        want_j_n;
	logic              in_range;
	logic [ROW_AW-1:0] bit_row;
	logic              issue_ok;
	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ROW_AW-1:0] ram_raddr;
	logic [ROW_W-1:0]  ram_rdata;
	logic [ROW_W-1:0]  wr_word;
	logic [ROW_W-1:0]  free_c;
	logic [ROW_W-1:0]  p_c [7];
	logic [ROW_W-1:0]  a_c;
	logic [CNT_W-1:0]  first_used;
	logic [CNT_W-1:0]  top_used;
	logic [CNT_W-1:0]  ina;
	logic              all_free;
	logic [RUN_W:0]    sum_c;
	logic              hit_a;
	logic              hit_b;
	logic              hit;
	logic              last_row;
	logic [RUN_W:0]    base_c;
	logic [UNIT_W-1:0] start_c;
	logic [RUN_W-1:0]  carry_nxt;

	// searched length
	assign bytes_c     = (map_bytes_q > MAPB_W'(BYTES_CAP)) ? MAPB_W'(BYTES_CAP) : map_bytes_q;
	assign rows_used_c = SROW_W'((11'(bytes_c) + 11'd7) >> 3);

	assign want_n   = (in_run_length == '0) ? RUN_W'(1) : in_run_length;
	assign want_j_n = msb_pos(want_n[CNT_W-1:0]);

	assign in_range = (20'(idx_q) < 20'(UNITS_MAX));
	assign bit_row  = ROW_AW'(idx_q >> ROW_IW);
	assign issue_ok = cmd.scan_step && (scan_row_q < rows_used_c);

	assign wr_word = (ram_rdata & ~(ROW_W'(1) << idx_q[ROW_IW-1:0]))
		| (ROW_W'(wv_q) << idx_q[ROW_IW-1:0]);

	assign ram_we    = cmd.clr_step || (cmd.bit_wb && (kind_q == KIND_WRITE) && in_range);
	assign ram_waddr = cmd.clr_step ? clr_row_q : bit_row;
	assign ram_wdata = cmd.clr_step ? '0 : wr_word;
	assign ram_re    = cmd.bit_rd || issue_ok;
	assign ram_raddr = cmd.bit_rd ? bit_row : ROW_AW'(scan_row_q);

	bfa_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// free units of the row, bytes past the searched length count as used
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			free_c[b*8 +: 8] = ({row_s1, 3'(b)} < 11'(bytes_c)) ? ~ram_rdata[b*8 +: 8] : 8'h00;
		end
	end

	// p_c[k] marks starts of free runs of length 2**k
	always_comb begin
		p_c[0] = free_c;
		for (int k = 1; k < 7; k++) begin
			p_c[k] = p_c[k-1] & (p_c[k-1] >> (1 << (k - 1)));
		end
	end

	assign a_c        = p_c[want_j_q] & (p_c[want_j_q] >> want_sh_q);
	assign first_used = first_one(~free_c);
	assign top_used   = last_one(~free_c);
	assign ina        = first_one(a_c);
	assign all_free   = &free_c;

	assign sum_c    = (RUN_W+1)'(carry_q) + (RUN_W+1)'(first_used);
	assign hit_a    = (sum_c >= (RUN_W+1)'(want_q));
	assign hit_b    = small_q && (a_c != '0);
	assign hit      = v_s1 && (hit_a || hit_b);
	assign last_row = v_s1 && (row_s1 == rows_used_c - SROW_W'(1));
	assign base_c   = {row_s1, {ROW_IW{1'b0}}};
	assign start_c  = hit_a ? UNIT_W'(base_c - (RUN_W+1)'(carry_q))
		: UNIT_W'(base_c + (RUN_W+1)'(ina));
	assign carry_nxt = all_free ? RUN_W'((RUN_W+1)'(carry_q) + (RUN_W+1)'(ROW_W))
		: RUN_W'(CNT_W'(ROW_W - 1) - top_used);

	assign stat.clr_last = (clr_row_q == ROW_AW'(ROWS - 1));
	assign stat.scan_end = hit || last_row || (rows_used_c == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_bytes_q <= MAPB_W'(512);
			clr_row_q   <= '0;
			scan_row_q  <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) map_bytes_q <= cfg_wdata;
			if (cmd.clr_step) clr_row_q <= stat.clr_last ? '0 : clr_row_q + ROW_AW'(1);
			if (cmd.latch) begin
				scan_row_q <= '0;
			end else if (issue_ok) begin
				scan_row_q <= scan_row_q + SROW_W'(1);
			end
			v_s1 <= issue_ok;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= scan_row_q;
		if (cmd.latch) begin
			kind_q    <= in_kind;
			idx_q     <= in_unit_idx;
			wv_q      <= in_write_value;
			want_q    <= want_n;
			want_j_q  <= want_j_n;
			want_sh_q <= ROW_IW'(want_n[CNT_W-1:0] - (CNT_W'(1) << want_j_n));
			small_q   <= (want_n <= RUN_W'(ROW_W));
			carry_q   <= '0;
			bit_res_q <= 1'b0;
			found_q   <= 1'b0;
			start_q   <= '0;
		end else begin
			if (cmd.bit_wb) begin
				bit_res_q <= (kind_q == KIND_READ) && in_range && ram_rdata[idx_q[ROW_IW-1:0]];
			end
			if (cmd.scan_step && v_s1) begin
				if (hit) begin
					found_q <= 1'b1;
					start_q <= start_c;
				end else begin
					carry_q <= carry_nxt;
				end
			end
		end
		if (cmd.load_out) out_data_q <= {2'b00, start_q, found_q, bit_res_q};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !ram_we)
		else $error("map written during search");

	a_found_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[1]) |-> !out_data_q[0])
		else $error("search result carries a read bit");

	a_row_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && v_s1) |-> (row_s1 < rows_used_c))
		else $error("row past searched length examined");
`endif

endmodule

/* hdl/bitmap_first_fit_allocator.sv */
// read or write bit: word out 3 cycles after acceptance (row read, modify-write, result)
// find: up to ceil(map_bytes/8) + 2 cycles, one 64-unit map row examined per cycle
// clear all: MAP_BYTES/8 rounded up + 1 cycles, one map row zeroed per cycle
// one word at a time; next word taken once the result is in the output register
// reset: map_bytes = 512, then a clearing pass of MAP_BYTES/8 rounded up cycles
// zeroes the map before the first input word is taken
module bitmap_first_fit_allocator
	import bfa_pkg::*;
#(
	parameter int MAP_BYTES = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MAPB_W-1:0] cfg_wdata,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,  // unit_idx, write_value, run_length
	input  logic [1:0]        s_axis_tuser,  // kind
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata   // bit_value, found, start_index
);

	cmd_t  cmd;
	stat_t stat;
	kind_t in_kind;

	assign in_kind = kind_t'(s_axis_tuser);

	bfa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_kind (in_kind),
		.stat    (stat),
		.cmd     (cmd)
	);

	bfa_dp #(
		.MAP_BYTES(MAP_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_kind       (in_kind),
		.in_unit_idx   (s_axis_tdata[UNIT_W-1:0]),
		.in_write_value(s_axis_tdata[UNIT_W]),
		.in_run_length (s_axis_tdata[UNIT_W+RUN_W:UNIT_W+1]),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata)
	);

endmodule

/* dv/tb_top.sv */
module tb_top;
	import bfa_pkg::*;

	localparam int MAP_BYTES    = 512;
	localparam int STORE_UNITS  = MAP_BYTES * 8;
	localparam int LIMIT_CYCLES = 1000000;

	typedef struct packed {
		logic              bit_value;
		logic              found;
		logic [UNIT_W-1:0] start_index;
	} alloc_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [MAPB_W-1:0] cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;  // unit_idx, write_value, run_length
	logic [1:0]        s_axis_tuser = '0;  // kind
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;       // bit_value, found, start_index

	logic [7:0]        alloc_map [MAP_BYTES];
	logic [MAPB_W-1:0] map_len = MAPB_W'(512);
	alloc_result_t     expected_results [$];
	int                errors = 0;
	int                cycles = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                stall_len = 0;
	int                stall_left = 0;

	bitmap_first_fit_allocator #(
		.MAP_BYTES(MAP_BYTES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("bitmap_first_fit_allocator regression: fail");
			$finish;
		end
	end

	// receiver: random holds plus one long stall on request
	always @(negedge clk) begin
		if (stall_len != 0) begin
			stall_left = stall_len;
			stall_len = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(string what, int want_v, int got_v);
		if (errors < 50)
			$display("mismatch %s: expected %0d got %0d (cycle %0d)", what, want_v, got_v, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		alloc_result_t exp_word;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("word with none expected", 0, m_axis_tdata);
			end else begin
				exp_word = expected_results.pop_front();
				if (m_axis_tdata[0] !== exp_word.bit_value)
					report_mismatch("bit_value", exp_word.bit_value, m_axis_tdata[0]);
				if (m_axis_tdata[1] !== exp_word.found)
					report_mismatch("found", exp_word.found, m_axis_tdata[1]);
				if (m_axis_tdata[13:2] !== exp_word.start_index)
					report_mismatch("start_index", exp_word.start_index, m_axis_tdata[13:2]);
			end
		end
	end

	function automatic int span_units();
		return (map_len > MAP_BYTES ? MAP_BYTES : map_len) * 8;
	endfunction

	function automatic logic unit_bit(int unit);
		if (unit >= STORE_UNITS)
			return 1'b0;
		return alloc_map[unit / 8][unit % 8];
	endfunction

	// lowest run of free units inside the searched span
	function automatic logic first_free_run(int want, output logic [UNIT_W-1:0] start);
		int span;
		int run;
		span = span_units();
		run = 0;
		start = '0;
		if (want == 0)
			want = 1;
		if (want > span)
			return 1'b0;
		for (int i = 0; i < span; i++) begin
			run = unit_bit(i) ? 0 : run + 1;
			if (run == want) begin
				start = UNIT_W'(i + 1 - want);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic alloc_result_t apply_word(kind_t kind, int idx, logic wv, int want);
		alloc_result_t r;
		logic [UNIT_W-1:0] start;
		r = '0;
		case (kind)
			KIND_READ: begin
				r.bit_value = unit_bit(idx);
			end
			KIND_WRITE: begin
				if (idx < STORE_UNITS)
					alloc_map[idx / 8][idx % 8] = wv;
			end
			KIND_FIND: begin
				r.found = first_free_run(want, start);
				r.start_index = start;
			end
			default: begin
				foreach (alloc_map[b])
					alloc_map[b] = '0;
			end
		endcase
		return r;
	endfunction

	task automatic send_word(kind_t kind, int idx, logic wv, int want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {6'd0, RUN_W'(want), wv, UNIT_W'(idx)};
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(apply_word(kind, idx & 'hfff, wv, want & 'h1fff));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_map_len(int len);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= MAPB_W'(len);
		map_len = MAPB_W'(len);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// allocation sequences, frees, searches, reads, clears and noise
	task automatic random_traffic(int count);
		int sent;
		int span;
		int pick;
		int base;
		int len;
		logic [UNIT_W-1:0] found_at;
		sent = 0;
		while (sent < count) begin
			span = span_units();
			pick = $urandom_range(99);
			if (pick < 30) begin
				len = $urandom_range(1, 12);
				send_word(KIND_FIND, $urandom, $urandom, len);
				sent++;
				if (first_free_run(len, found_at)) begin
					for (int j = 0; j < len; j++)
						send_word(KIND_WRITE, found_at + j, 1'b1, $urandom);
					sent += len;
				end
			end else if (pick < 45) begin
				base = $urandom_range(0, span == 0 ? STORE_UNITS - 1 : span - 1);
				len = $urandom_range(1, 16);
				for (int j = 0; j < len; j++)
					send_word(KIND_WRITE, base + j, 1'b0, $urandom);
				sent += len;
			end else if (pick < 70) begin
				case ($urandom_range(9))
					0: len = $urandom_range(8191);
					1, 2: len = $urandom_range(1, span + 8);
					default: len = $urandom_range(64);
				endcase
				send_word(KIND_FIND, $urandom, $urandom, len);
				sent++;
			end else if (pick < 85) begin
				base = (span == 0 || $urandom_range(3) == 0) ? $urandom_range(4095) :
					$urandom_range(span - 1);
				send_word(KIND_READ, base, $urandom, $urandom);
				sent++;
			end else if (pick < 87) begin
				send_word(KIND_CLEAR, $urandom, $urandom, $urandom);
				sent++;
			end else begin
				send_word(kind_t'($urandom_range(2)), $urandom, $urandom, $urandom);
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		send_word(KIND_READ, 0, 1'b0, 0);
		send_word(KIND_READ, 4095, 1'b0, 0);
		send_word(KIND_WRITE, 4095, 1'b1, 0);
		send_word(KIND_READ, 4095, 1'b0, 0);
		send_word(KIND_FIND, 0, 1'b0, 4096);
		send_word(KIND_FIND, 0, 1'b0, 4095);
		send_word(KIND_WRITE, 3, 1'b1, 0);
		send_word(KIND_FIND, 0, 1'b0, 4);
		send_word(KIND_FIND, 0, 1'b0, 0);
		send_word(KIND_WRITE, 3, 1'b0, 0);
		send_word(KIND_READ, 3, 1'b0, 0);
		send_word(KIND_FIND, 4095, 1'b1, 8191);
		send_word(KIND_CLEAR, 4095, 1'b1, 8191);
		send_word(KIND_FIND, 0, 1'b0, 4096);
		send_word(KIND_READ, 4095, 1'b1, 8191);
	endtask

	task automatic test_map_len_extremes();
		set_map_len(0);
		send_word(KIND_FIND, 0, 1'b0, 1);
		send_word(KIND_WRITE, 100, 1'b1, 0);
		send_word(KIND_READ, 100, 1'b0, 0);
		set_map_len(1);
		send_word(KIND_FIND, 0, 1'b0, 8);
		send_word(KIND_FIND, 0, 1'b0, 9);
		send_word(KIND_WRITE, 0, 1'b1, 0);
		send_word(KIND_FIND, 0, 1'b0, 7);
		send_word(KIND_FIND, 0, 1'b0, 8);
		set_map_len(1023);
		send_word(KIND_FIND, 0, 1'b0, 3995);
		send_word(KIND_FIND, 0, 1'b0, 3996);
		send_word(KIND_CLEAR, 0, 1'b0, 0);
	endtask

	task automatic test_backpressure();
		set_map_len(512);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_len = 300;
		random_traffic(24);
	endtask

	task automatic test_random_traffic();
		set_map_len(512);
		send_idle_pct = 15;
		recv_idle_pct = 76;
		random_traffic(400);
		set_map_len($urandom_range(1, 64));
		send_idle_pct = 76;
		recv_idle_pct = 15;
		random_traffic(400);
		set_map_len($urandom_range(513, 1023));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_traffic(200);
		set_map_len($urandom_range(65, 512));
		random_traffic(200);
	endtask

	initial begin
		foreach (alloc_map[b])
			alloc_map[b] = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_map_len_extremes();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (80) @(posedge clk);
		if (errors == 0) begin
			$display("bitmap_first_fit_allocator regression: pass");
		end else begin
			$display("bitmap_first_fit_allocator regression: fail");
		end
		$finish;
	end

endmodule

/* bitmap_first_fit_allocator.f */
hdl/bfa_pkg.sv
hdl/bfa_ram.sv
hdl/bfa_ctrl.sv
hdl/bfa_dp.sv
hdl/bitmap_first_fit_allocator.sv
dv/tb_top.sv
